[rtl/mad_pkg.sv]
// Shared types and constants of the max-magnitude decimator.
package mad_pkg;

	localparam int CNT_W = 13;
	localparam int POS_W = 12;
	localparam int SMP_W = 16;
	localparam logic [CNT_W-1:0] FRAME_MAX = 13'd4096;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_CALC,
		ST_RUN,
		ST_REPEAT
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic div_start;
		logic load_steps;
		logic take;
		logic rep_emit;
		logic rep_skip;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic up_mode;
		logic slot_free;
		logic item_end;
		logic rep_full;
	} sts_t;

endpackage

[rtl/mad_divider.sv]
// Restoring divider that yields the integer and remainder step, one bit a cycle.
module mad_divider import mad_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CNT_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [CNT_W-1:0] quotient,
	output logic [CNT_W-1:0] remainder
);

	localparam int CW = $clog2(CNT_W);
	localparam logic [CW-1:0] LAST = CW'(CNT_W - 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [CNT_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W:0]   shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[CNT_W-1]};
	assign fits    = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[CNT_W-2:0], fits};
			rem_q <= fits ? CNT_W'(shifted - {1'b0, divisor}) : shifted[CNT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[rtl/mad_ctrl.sv]
// Sequencer of the decimator: step load, item intake and repeat emission.
module mad_ctrl import mad_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: state_d = ST_CALC;
			ST_CALC: begin
				if (sts.div_done) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (in_valid && sts.slot_free && sts.up_mode) state_d = ST_REPEAT;
			end
			ST_REPEAT: begin
				if (sts.item_end && (sts.slot_free || cmd.rep_skip)) state_d = ST_RUN;
			end
			default: state_d = ST_RUN;
		endcase
		if (cfg_wr) state_d = ST_LOAD;
	end

	// Skip mode: once the repeat counter is full, step on without output.
	logic skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
		end else if (state_q != ST_REPEAT || cfg_wr) begin
			skip_q <= 1'b0;
		end else if (cmd.rep_emit && sts.rep_full && !sts.item_end) begin
			skip_q <= 1'b1;
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_LOAD: cmd.div_start = 1'b1;
			ST_CALC: cmd.load_steps = sts.div_done;
			ST_RUN: begin
				in_ready = sts.slot_free;
				cmd.take = in_valid && sts.slot_free;
			end
			ST_REPEAT: begin
				cmd.rep_skip = skip_q;
				cmd.rep_emit = !skip_q && sts.slot_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

[rtl/mad_datapath.sv]
// Counters, step registers, peak tracking and output register of the decimator.
module mad_datapath import mad_pkg::*; #(
	parameter int MAX_REPEAT = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] in_count,
	input  logic [CNT_W-1:0] out_count,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [SMP_W-1:0] sample,
	output logic             o_valid,
	input  logic             o_ready,
	output logic [SMP_W-1:0] o_value,
	output logic [POS_W-1:0] o_index,
	output logic             o_run_last,
	output logic             o_frame_last,
	output logic             o_clipped
);

	localparam int RW = $clog2(MAX_REPEAT);
	localparam int PW = CNT_W + $clog2(MAX_REPEAT + 1);
	localparam logic [RW-1:0] REP_LAST = RW'(MAX_REPEAT - 1);

	function automatic logic [SMP_W:0] mag(input logic [SMP_W-1:0] v);
		mag = v[SMP_W-1] ? (~{v[SMP_W-1], v} + 1'b1) : {1'b0, v};
	endfunction

	// control state
	logic [POS_W-1:0] in_pos_q;
	logic [CNT_W-1:0] out_pos_q;
	logic [CNT_W-1:0] bucket_end_q;
	logic [POS_W-1:0] rem_q;
	logic [CNT_W-1:0] step_whole_q;
	logic [POS_W-1:0] step_frac_q;
	logic             peak_valid_q;
	logic [RW-1:0]    rep_cnt_q;
	logic             clip_q;
	logic             o_valid_q;
	// payload
	logic [SMP_W-1:0] peak_q;
	logic [SMP_W-1:0] samp_q;

	logic [CNT_W-1:0] n_eff, w_eff;
	logic             zero_mode, dec_mode, eq_mode, up_mode;
	logic [CNT_W-1:0] in_next, out_next;
	logic             in_done, out_end;
	logic [CNT_W-1:0] r_sum;
	logic             carry;
	logic [POS_W-1:0] r_adv;
	logic [CNT_W-1:0] be_adv;
	logic [CNT_W-1:0] rs_be;
	logic [POS_W-1:0] rs_rem;
	logic             better, hit, dec_last, item_end, rep_full, clip;
	logic [SMP_W-1:0] cand;
	logic [PW-1:0]    reach;
	logic             div_done;
	logic [CNT_W-1:0] quo, div_rem;

	mad_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (n_eff),
		.divisor   (w_eff),
		.done      (div_done),
		.quotient  (quo),
		.remainder (div_rem)
	);

	always_comb begin
		n_eff = in_count;
		if (in_count == '0) n_eff = CNT_W'(1);
		else if (in_count > FRAME_MAX) n_eff = FRAME_MAX;
		w_eff = (out_count > FRAME_MAX) ? FRAME_MAX : out_count;
	end

	assign zero_mode = (w_eff == '0);
	assign dec_mode  = !zero_mode && (n_eff > w_eff);
	assign eq_mode   = !zero_mode && (n_eff == w_eff);
	assign up_mode   = !zero_mode && (n_eff < w_eff);

	assign in_next  = {1'b0, in_pos_q} + 1'b1;
	assign out_next = out_pos_q + 1'b1;
	assign in_done  = in_next >= n_eff;
	assign out_end  = out_next >= w_eff;

	// one Bresenham step
	assign r_sum  = {1'b0, rem_q} + {1'b0, step_frac_q};
	assign carry  = r_sum >= w_eff;
	assign r_adv  = carry ? POS_W'(r_sum - w_eff) : r_sum[POS_W-1:0];
	assign be_adv = bucket_end_q + step_whole_q + {{(CNT_W-1){1'b0}}, carry};

	// restart values: the first bucket end is set up only when decimating
	assign rs_be  = dec_mode ? step_whole_q : '0;
	assign rs_rem = dec_mode ? step_frac_q : '0;

	assign better   = !peak_valid_q || (mag(sample) > mag(peak_q));
	assign cand     = better ? sample : peak_q;
	assign hit      = in_next >= bucket_end_q;
	assign dec_last = out_end || in_done;
	assign item_end = carry || out_end;
	assign rep_full = rep_cnt_q == REP_LAST;

	// more than MAX_REPEAT points fall on this item when the remainder
	// still stays below the output count after that many steps
	assign reach = PW'(rem_q) + PW'(step_frac_q) * PW'(MAX_REPEAT);
	assign clip  = reach < PW'(w_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pos_q     <= '0;
			out_pos_q    <= '0;
			bucket_end_q <= '0;
			rem_q        <= '0;
			step_whole_q <= CNT_W'(1);
			step_frac_q  <= '0;
			peak_valid_q <= 1'b0;
			rep_cnt_q    <= '0;
			clip_q       <= 1'b0;
			o_valid_q    <= 1'b0;
		end else begin
			if (o_valid_q && o_ready) o_valid_q <= 1'b0;

			if (cmd.load_steps) begin
				step_whole_q <= zero_mode ? '0 : quo;
				step_frac_q  <= zero_mode ? '0 : div_rem[POS_W-1:0];
				bucket_end_q <= dec_mode ? quo : '0;
				rem_q        <= dec_mode ? div_rem[POS_W-1:0] : '0;
				in_pos_q     <= '0;
				out_pos_q    <= '0;
				peak_valid_q <= 1'b0;
			end

			if (cmd.take && dec_mode) begin
				if (hit) begin
					o_valid_q    <= 1'b1;
					peak_valid_q <= 1'b0;
					if (dec_last) begin
						in_pos_q     <= '0;
						out_pos_q    <= '0;
						bucket_end_q <= rs_be;
						rem_q        <= rs_rem;
					end else begin
						in_pos_q     <= in_next[POS_W-1:0];
						out_pos_q    <= out_next;
						bucket_end_q <= be_adv;
						rem_q        <= r_adv;
					end
				end else begin
					peak_valid_q <= 1'b1;
					in_pos_q     <= in_next[POS_W-1:0];
				end
			end

			if (cmd.take && eq_mode) begin
				o_valid_q <= 1'b1;
				if (out_end) begin
					in_pos_q     <= '0;
					out_pos_q    <= '0;
					bucket_end_q <= rs_be;
					rem_q        <= rs_rem;
				end else begin
					in_pos_q  <= in_next[POS_W-1:0];
					out_pos_q <= out_next;
				end
			end

			if (cmd.take && up_mode) begin
				rep_cnt_q <= '0;
				clip_q    <= clip;
			end

			if (cmd.rep_emit || cmd.rep_skip) begin
				if (cmd.rep_emit) begin
					o_valid_q <= 1'b1;
					rep_cnt_q <= rep_cnt_q + 1'b1;
				end
				if (item_end && in_done) begin
					in_pos_q     <= '0;
					out_pos_q    <= '0;
					bucket_end_q <= rs_be;
					rem_q        <= rs_rem;
				end else begin
					out_pos_q    <= out_next;
					bucket_end_q <= be_adv;
					rem_q        <= r_adv;
					if (item_end) in_pos_q <= in_next[POS_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && dec_mode) begin
			peak_q <= cand;
			if (hit) begin
				o_value      <= cand;
				o_index      <= out_pos_q[POS_W-1:0];
				o_run_last   <= 1'b1;
				o_frame_last <= dec_last;
				o_clipped    <= 1'b0;
			end
		end
		if (cmd.take && eq_mode) begin
			o_value      <= sample;
			o_index      <= out_pos_q[POS_W-1:0];
			o_run_last   <= 1'b1;
			o_frame_last <= out_end;
			o_clipped    <= 1'b0;
		end
		if (cmd.take && up_mode) samp_q <= sample;
		if (cmd.rep_emit) begin
			o_value      <= samp_q;
			o_index      <= out_pos_q[POS_W-1:0];
			o_run_last   <= item_end || rep_full;
			o_frame_last <= (item_end || rep_full) && in_done;
			o_clipped    <= clip_q;
		end
	end

	assign o_valid = o_valid_q;

	always_comb begin
		sts.div_done  = div_done;
		sts.up_mode   = up_mode;
		sts.slot_free = !o_valid_q || o_ready;
		sts.item_end  = item_end;
		sts.rep_full  = rep_full;
	end

endmodule

[rtl/max_abs_decimator.sv]
// Top level of the max-magnitude decimator: register port, sequencer and datapath.
//
// Resamples each frame of input_count signed 16-bit samples onto output_count display
// points. When input_count exceeds output_count, every bucket (bounds by integer and
// remainder Bresenham steps) gives one beat carrying its largest-magnitude sample,
// the earliest on a tie; equal counts pass samples through; a smaller input_count
// repeats each sample over the points that map to it, at most MAX_REPEAT beats per
// sample, with the clipped flag set on all of them when more points fell on it.
// Decimation and pass-through take one sample per cycle while the point stream keeps
// up; a result beat waiting in the output register holds the input until it leaves.
// Upsampling walks the points that map to a sample, skipped ones included, with one
// shared step unit, one point a cycle while the point stream keeps up, and takes the
// next sample only once the walk ends. Writing a register aborts the frame and
// recomputes the steps with a restoring divider, one quotient bit a cycle: no sample is
// taken until the divider is done and the new steps are loaded. An output_count of zero
// swallows samples. Registers: input_count at byte address 0, output_count at 4.
module max_abs_decimator import mad_pkg::*; #(
	parameter int MAX_REPEAT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// sample stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	// point stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] value, [27:16] point_index, [31:28] zero
	output logic        m_tlast,   // frame_last
	output logic [1:0]  m_tuser    // [0] run_last, [1] clipped
);

	logic [CNT_W-1:0] in_count_q;
	logic [CNT_W-1:0] out_count_q;
	logic             cfg_wr;
	cmd_t             cmd;
	sts_t             sts;
	logic [SMP_W-1:0] o_value;
	logic [POS_W-1:0] o_index;
	logic             o_run_last;
	logic             o_frame_last;
	logic             o_clipped;

	// Register port: word-aligned, address bit 2 picks the register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_count_q  <= CNT_W'(1);
			out_count_q <= CNT_W'(1);
		end else if (cfg_wr) begin
			if (paddr[2]) out_count_q <= pwdata[CNT_W-1:0];
			else          in_count_q  <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = paddr[2] ? {{(32-CNT_W){1'b0}}, out_count_q}
	                         : {{(32-CNT_W){1'b0}}, in_count_q};

	// Sequencer: hold intake while the steps load or repeats drain.
	mad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: advance the Bresenham counters and fill the output register.
	mad_datapath #(
		.MAX_REPEAT (MAX_REPEAT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_count     (in_count_q),
		.out_count    (out_count_q),
		.cmd          (cmd),
		.sts          (sts),
		.sample       (s_tdata[SMP_W-1:0]),
		.o_valid      (m_tvalid),
		.o_ready      (m_tready),
		.o_value      (o_value),
		.o_index      (o_index),
		.o_run_last   (o_run_last),
		.o_frame_last (o_frame_last),
		.o_clipped    (o_clipped)
	);

	assign m_tdata = {{(32-SMP_W-POS_W){1'b0}}, o_index, o_value};
	assign m_tlast = o_frame_last;
	assign m_tuser = {o_clipped, o_run_last};

	// A repeat beat never overwrites a beat still waiting downstream.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rep_emit |-> sts.slot_free)
		else $error("repeat beat issued while output register is occupied");

	// No sample is taken in the cycle after the divider starts.
	a_hold_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !s_tready)
		else $error("sample taken while steps are being computed");

	// The end of a frame is always the end of a sample's run.
	a_frame_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0])
		else $error("frame end without run end");

	// At most one datapath operation per cycle.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.rep_emit, cmd.rep_skip, cmd.load_steps}))
		else $error("conflicting datapath commands");

endmodule

[sim/max_abs_decimator_checker.sv]
// Point-stream checker: tracks register writes, predicts every point beat and compares it.
`timescale 1ns / 1ps
module max_abs_decimator_checker import mad_pkg::*; #(
	parameter int         REPEAT_CAP     = 64,
	parameter logic [2:0] ADDR_IN_COUNT  = 3'd0,
	parameter logic [2:0] ADDR_OUT_COUNT = 3'd4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [15:0] value, [27:16] point_index, [31:28] zero
	input  logic        m_tlast,   // frame_last
	input  logic [1:0]  m_tuser,   // [0] run_last, [1] clipped
	output int          mismatches,
	output int          points_owed,
	output int          points_checked,
	output int          clipped_seen,
	output int          frames_seen
);

	typedef struct packed {
		logic [SMP_W-1:0] value;
		logic [POS_W-1:0] index;
		logic             run_last;
		logic             frame_last;
		logic             clipped;
	} point_t;

	logic [CNT_W-1:0]        cfg_in;
	logic [CNT_W-1:0]        cfg_out;
	logic [POS_W-1:0]        in_pos;
	logic [CNT_W-1:0]        out_pos;
	logic [CNT_W-1:0]        bucket_end;
	logic [POS_W-1:0]        rem_acc;
	logic [CNT_W-1:0]        step_whole;
	logic [POS_W-1:0]        step_frac;
	logic signed [SMP_W-1:0] running_peak;
	logic                    peak_valid;
	point_t                  owed_points[$];

	// Count as the block uses it: clamp to the frame limit, and an input count of zero is one.
	function automatic logic [CNT_W-1:0] frame_len(input logic [CNT_W-1:0] cnt,
			input logic floor_one);
		if (cnt == '0 && floor_one)
			return CNT_W'(1);
		if (cnt > FRAME_MAX)
			return FRAME_MAX;
		return cnt;
	endfunction

	function automatic logic [SMP_W:0] magnitude(input logic signed [SMP_W-1:0] v);
		logic signed [SMP_W:0] wide;
		wide = v;
		return (wide < 0) ? -wide : wide;
	endfunction

	task automatic step_bucket(input logic [CNT_W-1:0] w);
		logic [CNT_W-1:0] sum;
		bucket_end = bucket_end + step_whole;
		sum = rem_acc + step_frac;
		if (sum >= w) begin
			bucket_end = bucket_end + 1'b1;
			rem_acc = POS_W'(sum - w);
		end else begin
			rem_acc = POS_W'(sum);
		end
	endtask

	task automatic restart_frame();
		logic [CNT_W-1:0] n;
		logic [CNT_W-1:0] w;
		n = frame_len(cfg_in, 1'b1);
		w = frame_len(cfg_out, 1'b0);
		in_pos = '0;
		out_pos = '0;
		rem_acc = '0;
		bucket_end = '0;
		running_peak = '0;
		peak_valid = 1'b0;
		if (w == '0) begin
			step_whole = '0;
			step_frac = '0;
		end else begin
			step_whole = n / w;
			step_frac = POS_W'(n - step_whole * w);
			if (n > w)
				step_bucket(w);
		end
	endtask

	// Work out the points one accepted sample causes and queue them.
	task automatic take_sample(input logic signed [SMP_W-1:0] smp);
		logic [CNT_W-1:0] n;
		logic [CNT_W-1:0] w;
		point_t           pt;
		point_t           run_pts[$];
		int unsigned      total;
		logic             done;
		n = frame_len(cfg_in, 1'b1);
		w = frame_len(cfg_out, 1'b0);
		if (w == '0)
			return;
		pt = '0;
		if (n > w) begin
			if (!peak_valid || magnitude(smp) > magnitude(running_peak)) begin
				running_peak = smp;
				peak_valid = 1'b1;
			end
			if (CNT_W'(in_pos) + 1'b1 >= bucket_end) begin
				pt.value = running_peak;
				pt.index = out_pos[POS_W-1:0];
				pt.run_last = 1'b1;
				out_pos = out_pos + 1'b1;
				peak_valid = 1'b0;
				running_peak = '0;
				if (out_pos >= w || CNT_W'(in_pos) + 1'b1 >= n) begin
					pt.frame_last = 1'b1;
					restart_frame();
				end else begin
					step_bucket(w);
					in_pos = in_pos + 1'b1;
				end
				owed_points.push_back(pt);
			end else begin
				in_pos = in_pos + 1'b1;
			end
		end else if (n == w) begin
			pt.value = smp;
			pt.index = out_pos[POS_W-1:0];
			pt.run_last = 1'b1;
			out_pos = out_pos + 1'b1;
			if (out_pos >= w) begin
				pt.frame_last = 1'b1;
				restart_frame();
			end else begin
				in_pos = in_pos + 1'b1;
			end
			owed_points.push_back(pt);
		end else begin
			total = 0;
			while (out_pos < w && bucket_end == CNT_W'(in_pos)) begin
				if (total < REPEAT_CAP) begin
					pt.value = smp;
					pt.index = out_pos[POS_W-1:0];
					run_pts.push_back(pt);
				end
				total++;
				out_pos = out_pos + 1'b1;
				step_bucket(w);
			end
			done = (CNT_W'(in_pos) + 1'b1 >= n) || (out_pos >= w);
			foreach (run_pts[k])
				run_pts[k].clipped = (total > REPEAT_CAP);
			if (run_pts.size() > 0) begin
				run_pts[run_pts.size()-1].run_last = 1'b1;
				run_pts[run_pts.size()-1].frame_last = done;
			end
			if (done)
				restart_frame();
			else
				in_pos = in_pos + 1'b1;
			foreach (run_pts[k])
				owed_points.push_back(run_pts[k]);
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		point_t got;
		point_t want;
		if (!arst_n) begin
			cfg_in = CNT_W'(1);
			cfg_out = CNT_W'(1);
			restart_frame();
			owed_points.delete();
			mismatches = 0;
			points_checked = 0;
			clipped_seen = 0;
			frames_seen = 0;
		end else begin
			// results first: a beat leaving now never stems from a sample taken now
			if (m_tvalid && m_tready) begin
				got.value = m_tdata[15:0];
				got.index = m_tdata[27:16];
				got.run_last = m_tuser[0];
				got.clipped = m_tuser[1];
				got.frame_last = m_tlast;
				if (owed_points.size() == 0) begin
					$error("point beat with nothing owed: value %0d, index %0d",
						$signed(got.value), got.index);
					mismatches++;
				end else begin
					want = owed_points.pop_front();
					check_field("value", $signed(want.value), $signed(got.value));
					check_field("point_index", want.index, got.index);
					check_field("run_last", want.run_last, got.run_last);
					check_field("frame_last", want.frame_last, got.frame_last);
					check_field("clipped", want.clipped, got.clipped);
				end
				points_checked++;
				if (got.clipped)
					clipped_seen++;
				if (got.frame_last)
					frames_seen++;
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_IN_COUNT) begin
					cfg_in = pwdata[CNT_W-1:0];
					restart_frame();
				end else if (paddr == ADDR_OUT_COUNT) begin
					cfg_out = pwdata[CNT_W-1:0];
					restart_frame();
				end
			end
			if (s_tvalid && s_tready)
				take_sample(s_tdata);
		end
		points_owed = owed_points.size();
	end

endmodule

[sim/max_abs_decimator_test.sv]
// Top of the decimator testbench: clock, reset, register writes, sample and point traffic.
`timescale 1ns / 1ps
module max_abs_decimator_test import mad_pkg::*;;

	localparam int         REPEAT_CAP     = 64;
	localparam logic [2:0] ADDR_IN_COUNT  = 3'd0;
	localparam logic [2:0] ADDR_OUT_COUNT = 3'd4;
	// quiet cycles before a register write, enough for the divider and a lone sample
	localparam int         SETTLE         = 40;
	localparam int         LONG_HOLD      = 300;
	localparam int         RANDOM_ITEMS   = 400;
	localparam int         CYCLE_LIMIT    = 1000000;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [15:0] sample
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [15:0] value, [27:16] point_index, [31:28] zero
	logic        m_tlast;   // frame_last
	logic [1:0]  m_tuser;   // [0] run_last, [1] clipped

	int   mismatches;
	int   points_owed;
	int   points_checked;
	int   clipped_seen;
	int   frames_seen;
	int   samples_sent = 0;
	int   settings_run = 0;
	int   burst_left = 0;
	int   cycle_count = 0;
	logic hold_toggle = 1'b0;

	// corner settings: input_count, output_count, samples to send (mostly partial frames)
	int extreme_set [8][3] = '{
		'{8191, 4096, 50},   // both counts saturate, long pass-through
		'{4096, 1, 70},      // one huge bucket, aborted long before full
		'{2, 4096, 2},       // widest upsampling, top index bit reached
		'{1, 8191, 1},       // single sample spread over the whole frame
		'{4095, 4096, 30},   // zero integer step, fraction only
		'{4096, 4095, 30},   // decimation by a hair
		'{0, 0, 5},          // zero input count read as one, nothing emitted
		'{3, 8191, 3}        // clipped repeats with a saturated output count
	};

	always #5 clk = ~clk;

	max_abs_decimator #(
		.MAX_REPEAT(REPEAT_CAP)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	max_abs_decimator_checker #(
		.REPEAT_CAP    (REPEAT_CAP),
		.ADDR_IN_COUNT (ADDR_IN_COUNT),
		.ADDR_OUT_COUNT(ADDR_OUT_COUNT)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser),
		.mismatches    (mismatches),
		.points_owed   (points_owed),
		.points_checked(points_checked),
		.clipped_seen  (clipped_seen),
		.frames_seen   (frames_seen)
	);

	// Watchdog: end the run if the traffic ever locks up.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d points still owed", cycle_count, points_owed);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: switch between stall patterns at random intervals, and on request
	// hold off for a long stretch so that the block fills up and stalls its input.
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       tick;
		logic     hold_seen;
		mode = RX_OPEN;
		mode_left = 0;
		tick = 0;
		hold_seen = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (mode)
					RX_OPEN:     m_tready <= 1'b1;
					RX_LIGHT:    m_tready <= ($urandom_range(0, 3) != 0);
					RX_HEAVY:    m_tready <= ($urandom_range(0, 3) == 0);
					RX_PERIODIC: m_tready <= ((tick % 5) != 0);
				endcase
			end
		end
	end

	// Offer one sample and hold it until taken. Runs from a falling edge to a falling edge;
	// the sender idles between bursts of random length, sometimes long ones with no gap.
	task automatic send_sample(input logic [15:0] smp);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0)
				gap = 0;
			else if ($urandom_range(0, 7) == 0)
				gap = $urandom_range(10, 30);
			else
				gap = $urandom_range(1, 4);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 16);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		samples_sent++;
	endtask

	// Drop valid and wait until every owed point has left.
	task automatic wait_points_out();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (points_owed != 0);
		burst_left = 0;
	endtask

	// Register write, only once the block has gone quiet; upper data bits are noise.
	task automatic write_count(input logic [2:0] addr, input logic [CNT_W-1:0] value);
		wait_points_out();
		// skipped repeats of a clipped sample may still be walking
		while (!s_tready) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {19'($urandom_range(0, 32'h7ffff)), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_counts(input int n, input int w);
		write_count(ADDR_IN_COUNT, CNT_W'(n));
		write_count(ADDR_OUT_COUNT, CNT_W'(w));
		settings_run++;
	endtask

	// Mostly full-range noise, with the extremes and a cluster of small values for ties.
	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2, 3:    return 16'($urandom_range(0, 8)) - 16'd4;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int n;
		int w;
		int cnt;
		int roll;
		int phase;
		int ext_next;
		int pause_at;
		int random_items;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		phase = 0;
		ext_next = 0;
		random_items = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset setting is one in, one out: every sample is its own frame.
		send_sample(16'h7fff);
		send_sample(16'h8000);
		send_sample(16'h0000);
		send_sample(16'hffff);
		send_sample(16'h5555);
		send_sample(16'haaaa);
		// Pairs per bucket: equal magnitudes keep the earlier sample, and the most
		// negative value outranks the most positive one.
		set_counts(4, 2);
		send_sample(16'd5);
		send_sample(-16'sd5);
		send_sample(16'd7);
		send_sample(-16'sd7);
		send_sample(16'h8000);
		send_sample(16'h7fff);
		send_sample(16'h7fff);
		send_sample(16'h8000);
		// Upsampling, then one sample whose repeats are cut at the cap.
		set_counts(2, 5);
		send_sample(16'd100);
		send_sample(-16'sd100);
		set_counts(1, 100);
		send_sample(16'd1234);
		// Zero output count swallows samples; zero input count acts as one.
		set_counts(3, 0);
		send_sample(16'd11);
		send_sample(16'd22);
		set_counts(0, 3);
		send_sample(-16'sd2);

		// Random settings, with the corner settings woven in on even phases.
		while (random_items < RANDOM_ITEMS) begin
			phase++;
			pause_at = -1;
			if (phase == 1) begin
				// pass-through under a long receiver hold-off
				n = 8;
				w = 8;
				cnt = 48;
			end else if (phase == 3) begin
				// decimation with a full pause of the sender half-way through
				n = 12;
				w = 5;
				cnt = 24;
				pause_at = 12;
			end else if (phase % 2 == 0 && ext_next < 8) begin
				n = extreme_set[ext_next][0];
				w = extreme_set[ext_next][1];
				cnt = extreme_set[ext_next][2];
				ext_next++;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 55) begin
					n = $urandom_range(1, 24);
					w = $urandom_range(1, 24);
				end else if (roll < 65) begin
					n = $urandom_range(1, 24);
					w = n;
				end else if (roll < 80) begin
					n = $urandom_range(1, 6);
					w = $urandom_range(n + 1, 40);
				end else if (roll < 88) begin
					n = $urandom_range(1, 2);
					w = $urandom_range(65, 200);
				end else if (roll < 95) begin
					w = $urandom_range(1, 4);
					n = $urandom_range(w + 8, 40);
				end else begin
					n = $urandom_range(1, 24);
					w = 0;
				end
				// whole frames, now and then a trailing partial one cut by the next write
				cnt = n * $urandom_range(1, 3);
				if ($urandom_range(0, 4) == 0)
					cnt += $urandom_range(1, n);
			end
			set_counts(n, w);
			if (phase == 1)
				hold_toggle <= ~hold_toggle;
			for (int i = 0; i < cnt; i++) begin
				if (i == pause_at)
					wait_points_out();
				send_sample(pick_sample());
			end
			if (w != 0)
				random_items += cnt;
		end

		// Drain, then give the block time to show any stray beat.
		wait_points_out();
		repeat (SETTLE) @(negedge clk);
		$display("Covered %0d samples over %0d count settings, corner and zero counts included.",
			samples_sent, settings_run);
		$display("Checked %0d points: %0d frame ends, %0d clipped repeats.",
			points_checked, frames_seen, clipped_seen);
		if (mismatches == 0 && points_owed == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
